FILE: sv/rbpa_pkg.sv
package rbpa_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int PAGE_UNITS  = 512;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int OFF_W       = $clog2(PAGE_UNITS);
    localparam int UNIT_W      = PAGE_W + OFF_W;
    localparam int TOTAL_UNITS = NUM_PAGES * PAGE_UNITS;
    localparam int ADDR_W      = 18;
    localparam int SIZE_W      = 16;
    localparam int CAP_W       = 10;
    localparam int REFS_W      = 9;
    localparam int DEPTH_W     = PAGE_W + 1;
    localparam int CNT_W       = 32;
    localparam int UNITS_W     = SIZE_W - 2;
    localparam int STAT_W      = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 10'd508;
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(PAGE_UNITS - 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_PAGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
    } t_dp_stat;

endpackage

FILE: sv/rbpa_ctrl.sv
module rbpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rbpa_pkg::t_dp_stat i_stat,
    output rbpa_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import rbpa_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec   = (r_state == S_EXEC);

endmodule

FILE: sv/rbpa_datapath.sv
module rbpa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbpa_pkg::t_dp_cmd             i_cmd,
    output rbpa_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [rbpa_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_op,
    input  logic [rbpa_pkg::SIZE_W-1:0]   i_alloc_size,
    input  logic [rbpa_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_valid,
    output logic [rbpa_pkg::STAT_W-1:0]   o_status,
    output logic [rbpa_pkg::ADDR_W-1:0]   o_address,
    output logic                          o_page_released,
    output logic [rbpa_pkg::CNT_W-1:0]    o_alloc_count,
    output logic [rbpa_pkg::CNT_W-1:0]    o_free_count,
    output logic [rbpa_pkg::CNT_W-1:0]    o_alloc_bytes
);
    import rbpa_pkg::*;

    // memories
    logic [CAP_W-1:0]  fill_mem  [NUM_PAGES];
    logic [REFS_W-1:0] refs_mem  [NUM_PAGES];
    logic [PAGE_W-1:0] stack_mem [NUM_PAGES];
    logic              mark_mem  [TOTAL_UNITS];

    // control and bookkeeping state
    logic [CAP_W-1:0]   r_cap;
    logic [PAGE_W-1:0]  r_cur_page;
    logic               r_cur_valid;
    logic [DEPTH_W-1:0] r_depth;
    logic [CNT_W-1:0]   r_alloc_cnt;
    logic [CNT_W-1:0]   r_free_cnt;
    logic [CNT_W-1:0]   r_byte_cnt;
    logic [UNIT_W-1:0]  r_clr_idx;
    logic               r_out_valid;

    // latched item and registered read data
    logic               r_op;
    logic [UNITS_W-1:0] r_units;
    logic [ADDR_W-1:0]  r_faddr;
    logic [CAP_W-1:0]   r_fill_rd;
    logic [REFS_W-1:0]  r_refs_rd;
    logic [PAGE_W-1:0]  r_stack_rd;
    logic               r_mark_rd;

    // result registers
    logic [STAT_W-1:0]  r_status;
    logic [ADDR_W-1:0]  r_address;
    logic               r_released;

    // accept-side address decode
    logic [SIZE_W:0]    size_pad;
    logic [UNITS_W-1:0] units_in;
    logic [UNIT_W-1:0]  hdr_in;
    logic [PAGE_W-1:0]  refs_ra;
    logic [PAGE_W-1:0]  stack_ra;

    assign size_pad = {1'b0, i_alloc_size} + (SIZE_W+1)'(15);
    assign units_in = size_pad[SIZE_W:3];
    assign hdr_in   = i_free_address[ADDR_W-1:3] - UNIT_W'(1);
    assign refs_ra  = (i_op == CMD_FREE) ? hdr_in[UNIT_W-1:OFF_W] : r_cur_page;
    assign stack_ra = PAGE_W'(r_depth - DEPTH_W'(1));

    // execute-side logic
    logic [CAP_W-1:0]   cap_eff;
    logic               too_big;
    logic               fits;
    logic               need_page;
    logic [PAGE_W-1:0]  a_page;
    logic [CAP_W-1:0]   a_fill;
    logic [REFS_W-1:0]  a_refs;
    logic [UNIT_W-1:0]  a_hdr;
    logic [UNIT_W-1:0]  a_hdr_next;
    logic [UNIT_W-1:0]  f_unit;
    logic [UNIT_W-1:0]  f_hdr;
    logic [PAGE_W-1:0]  f_page;
    logic               f_bad;
    logic [REFS_W-1:0]  f_refs;
    logic               f_is_cur;

    logic [STAT_W-1:0]  n_status;
    logic [ADDR_W-1:0]  n_address;
    logic               n_released;
    logic [PAGE_W-1:0]  n_cur_page;
    logic               n_cur_valid;
    logic [DEPTH_W-1:0] n_depth;
    logic [CNT_W-1:0]   n_alloc_cnt;
    logic [CNT_W-1:0]   n_free_cnt;
    logic [CNT_W-1:0]   n_byte_cnt;

    logic               fill_we;
    logic [PAGE_W-1:0]  fill_wa;
    logic [CAP_W-1:0]   fill_wd;
    logic               refs_we;
    logic [PAGE_W-1:0]  refs_wa;
    logic [REFS_W-1:0]  refs_wd;
    logic               stack_we;
    logic [PAGE_W-1:0]  stack_wa;
    logic [PAGE_W-1:0]  stack_wd;
    logic               mark_we;
    logic [UNIT_W-1:0]  mark_wa;
    logic               mark_wd;

    assign cap_eff   = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign too_big   = r_units > UNITS_W'(cap_eff);
    assign fits      = r_cur_valid &&
                       ((UNITS_W+1)'(r_fill_rd) + (UNITS_W+1)'(r_units) <=
                        (UNITS_W+1)'(cap_eff));
    assign need_page = !fits;
    assign a_page    = need_page ? r_stack_rd : r_cur_page;
    assign a_fill    = need_page ? '0 : r_fill_rd;
    assign a_refs    = need_page ? '0 : r_refs_rd;
    assign a_hdr     = {a_page, a_fill[OFF_W-1:0]};
    assign a_hdr_next = a_hdr + UNIT_W'(1);

    // the unit index cannot reach past the pool at this address width
    assign f_unit   = r_faddr[ADDR_W-1:3];
    assign f_hdr    = f_unit - UNIT_W'(1);
    assign f_page   = f_hdr[UNIT_W-1:OFF_W];
    assign f_bad    = (r_faddr[2:0] != 3'd0) || (f_unit[OFF_W-1:0] == '0) || !r_mark_rd;
    assign f_refs   = (r_refs_rd != '0) ? r_refs_rd - REFS_W'(1) : '0;
    assign f_is_cur = r_cur_valid && (f_page == r_cur_page);

    always_comb begin
        n_status    = STAT_OK;
        n_address   = '0;
        n_released  = 1'b0;
        n_cur_page  = r_cur_page;
        n_cur_valid = r_cur_valid;
        n_depth     = r_depth;
        n_alloc_cnt = r_alloc_cnt;
        n_free_cnt  = r_free_cnt;
        n_byte_cnt  = r_byte_cnt;
        fill_we     = 1'b0;
        fill_wa     = a_page;
        fill_wd     = a_fill + CAP_W'(r_units);
        refs_we     = 1'b0;
        refs_wa     = a_page;
        refs_wd     = a_refs + REFS_W'(1);
        stack_we    = 1'b0;
        stack_wa    = PAGE_W'(r_depth);
        stack_wd    = f_page;
        mark_we     = 1'b0;
        mark_wa     = a_hdr;
        mark_wd     = 1'b1;

        if (i_cmd.clear) begin
            mark_we  = 1'b1;
            mark_wa  = r_clr_idx;
            mark_wd  = 1'b0;
            // load the stack so that page 0 pops first
            stack_we = (r_clr_idx < UNIT_W'(NUM_PAGES));
            stack_wa = PAGE_W'(r_clr_idx);
            stack_wd = PAGE_W'(NUM_PAGES - 1) - PAGE_W'(r_clr_idx);
        end else if (i_cmd.exec) begin
            if (r_op == CMD_ALLOC) begin
                if (too_big) begin
                    n_status = STAT_TOO_LARGE;
                end else if (need_page && (r_depth == '0)) begin
                    n_status = STAT_NO_PAGE;
                end else begin
                    if (need_page) begin
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                    n_cur_page  = a_page;
                    n_cur_valid = 1'b1;
                    fill_we     = 1'b1;
                    refs_we     = 1'b1;
                    mark_we     = 1'b1;
                    n_alloc_cnt = r_alloc_cnt + CNT_W'(1);
                    n_byte_cnt  = r_byte_cnt + CNT_W'({r_units, 3'b000});
                    n_address   = {a_hdr_next, 3'b000};
                end
            end else begin
                if (f_bad) begin
                    n_status = STAT_BAD_FREE;
                end else begin
                    mark_we    = 1'b1;
                    mark_wa    = f_hdr;
                    mark_wd    = 1'b0;
                    refs_we    = 1'b1;
                    refs_wa    = f_page;
                    refs_wd    = f_refs;
                    fill_wa    = f_page;
                    fill_wd    = '0;
                    n_free_cnt = r_free_cnt + CNT_W'(1);
                    if (f_refs == '0) begin
                        // rewind the current page, release any other
                        if (f_is_cur) begin
                            fill_we = 1'b1;
                        end else if (r_depth < DEPTH_W'(NUM_PAGES)) begin
                            fill_we    = 1'b1;
                            stack_we   = 1'b1;
                            n_depth    = r_depth + DEPTH_W'(1);
                            n_released = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) fill_mem[fill_wa] <= fill_wd;
        if (i_cmd.accept) r_fill_rd <= fill_mem[r_cur_page];
    end

    always_ff @(posedge i_clk) begin
        if (refs_we) refs_mem[refs_wa] <= refs_wd;
        if (i_cmd.accept) r_refs_rd <= refs_mem[refs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) stack_mem[stack_wa] <= stack_wd;
        if (i_cmd.accept) r_stack_rd <= stack_mem[stack_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) mark_mem[mark_wa] <= mark_wd;
        if (i_cmd.accept) r_mark_rd <= mark_mem[hdr_in];
    end

    // latch the item and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_units <= units_in;
            r_faddr <= i_free_address;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_address  <= n_address;
            r_released <= n_released;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_cur_page  <= '0;
            r_cur_valid <= 1'b0;
            r_depth     <= DEPTH_W'(NUM_PAGES);
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_byte_cnt  <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + UNIT_W'(1);
            r_cur_page  <= n_cur_page;
            r_cur_valid <= n_cur_valid;
            r_depth     <= n_depth;
            r_alloc_cnt <= n_alloc_cnt;
            r_free_cnt  <= n_free_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_out_valid <= i_cmd.exec;
        end
    end

    assign o_stat.clear_done = i_cmd.clear && (r_clr_idx == UNIT_W'(TOTAL_UNITS - 1));

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_address       = r_address;
    assign o_page_released = r_released;
    assign o_alloc_count   = r_alloc_cnt;
    assign o_free_count    = r_free_cnt;
    assign o_alloc_bytes   = r_byte_cnt;

endmodule

FILE: sv/refcounted_bump_page_allocator.sv
// Channel   Handshake              Payload
// -------   --------------------   -----------------------------------------------
// request   start / busy           i_cmd, i_alloc_size, i_free_address
// result    o_valid (one cycle)    o_status, o_address, o_page_released,
//                                  o_alloc_count, o_free_count, o_alloc_bytes
// config    i_cfg_we               i_cfg_wdata (page_capacity_units)
//
// For every item, the accept edge reads the fill, refcount, free-stack
// and mark memories, the next edge writes them back and registers the result.
// o_valid rises the cycle after, when busy has dropped, so a new item may start.
// After reset a clearing pass sweeps the mark memory, one unit a cycle, and loads
// the free-page stack; busy stays high throughout.
// The receiver cannot stall; each result is shown for exactly one cycle.
module refcounted_bump_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [rbpa_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_cmd,
    input  logic [rbpa_pkg::SIZE_W-1:0]   i_alloc_size,
    input  logic [rbpa_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_valid,
    output logic [rbpa_pkg::STAT_W-1:0]   o_status,
    output logic [rbpa_pkg::ADDR_W-1:0]   o_address,
    output logic                          o_page_released,
    output logic [rbpa_pkg::CNT_W-1:0]    o_alloc_count,
    output logic [rbpa_pkg::CNT_W-1:0]    o_free_count,
    output logic [rbpa_pkg::CNT_W-1:0]    o_alloc_bytes
);
    import rbpa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    rbpa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_cmd),
        .i_alloc_size    (i_alloc_size),
        .i_free_address  (i_free_address),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_address       (o_address),
        .o_page_released (o_page_released),
        .o_alloc_count   (o_alloc_count),
        .o_free_count    (o_free_count),
        .o_alloc_bytes   (o_alloc_bytes)
    );

`ifndef SYNTH
    // a result only follows a cycle spent working on an item
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_released) |-> (o_status == STAT_OK))
        else $error("page released on a rejected request");

    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_address != '0)) |-> (o_status == STAT_OK))
        else $error("address returned on a rejected request");
`endif

endmodule

FILE: dv/tb_refcounted_bump_page_allocator.sv
module tb_refcounted_bump_page_allocator;
    import rbpa_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] address;
        logic              page_released;
        logic [CNT_W-1:0]  alloc_count;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  alloc_bytes;
    } t_alloc_reply;

    class t_alloc_scoreboard;
        logic [CAP_W-1:0]   cap_reg;
        logic [CAP_W-1:0]   page_fill [NUM_PAGES];
        logic [REFS_W-1:0]  page_refs [NUM_PAGES];
        logic [PAGE_W-1:0]  cur_page;
        logic               cur_valid;
        logic [PAGE_W-1:0]  free_stack [NUM_PAGES];
        logic [DEPTH_W-1:0] stack_depth;
        bit                 unit_marks [TOTAL_UNITS];
        logic [CNT_W-1:0]   allocs_done;
        logic [CNT_W-1:0]   frees_done;
        logic [CNT_W-1:0]   bytes_done;
        t_alloc_reply       predicted_replies [$];
        logic [ADDR_W-1:0]  live_addrs [$];
        logic [ADDR_W-1:0]  freed_addrs [$];
        int                 errors;

        function new();
            cap_reg = CAP_RESET;
            for (int i = 0; i < NUM_PAGES; i++) begin
                page_fill[i]  = '0;
                page_refs[i]  = '0;
                free_stack[i] = PAGE_W'(NUM_PAGES - 1 - i);
            end
            for (int u = 0; u < TOTAL_UNITS; u++) begin
                unit_marks[u] = 1'b0;
            end
            cur_page    = '0;
            cur_valid   = 1'b0;
            stack_depth = DEPTH_W'(NUM_PAGES);
            allocs_done = '0;
            frees_done  = '0;
            bytes_done  = '0;
            errors      = 0;
        endfunction

        function int usable_units();
            return (cap_reg > CAP_MAX) ? int'(CAP_MAX) : int'(cap_reg);
        endfunction

        function void predict_alloc(input logic [SIZE_W-1:0] size,
                                    output logic [STAT_W-1:0] st,
                                    output logic [ADDR_W-1:0] addr);
            int units;
            int cap;
            int fill;
            int hdr;
            logic [PAGE_W-1:0] pg;
            units = (int'(size) + 15) >> 3;
            cap   = usable_units();
            addr  = '0;
            if (units > cap) begin
                st = STAT_TOO_LARGE;
                return;
            end
            // open a fresh page when the current one cannot hold the item
            if (!(cur_valid && int'(page_fill[cur_page]) + units <= cap)) begin
                if (stack_depth == 0) begin
                    st = STAT_NO_PAGE;
                    return;
                end
                stack_depth = stack_depth - 1'b1;
                pg = free_stack[stack_depth];
                page_fill[pg] = '0;
                page_refs[pg] = '0;
                cur_page  = pg;
                cur_valid = 1'b1;
            end
            fill = int'(page_fill[cur_page]);
            hdr  = int'(cur_page) * PAGE_UNITS + fill;
            unit_marks[hdr]     = 1'b1;
            page_refs[cur_page] = page_refs[cur_page] + 1'b1;
            page_fill[cur_page] = CAP_W'(fill + units);
            allocs_done = allocs_done + 1'b1;
            bytes_done  = bytes_done + CNT_W'(units * 8);
            addr = ADDR_W'((hdr + 1) * 8);
            st   = STAT_OK;
            live_addrs.push_back(addr);
        endfunction

        function void predict_free(input logic [ADDR_W-1:0] addr,
                                   output logic [STAT_W-1:0] st,
                                   output logic released);
            int unit_idx;
            int hdr;
            logic [PAGE_W-1:0] pg;
            released = 1'b0;
            st = STAT_BAD_FREE;
            if (addr[2:0] != 3'd0)
                return;
            unit_idx = int'(addr >> 3);
            if (unit_idx >= TOTAL_UNITS || unit_idx % PAGE_UNITS == 0)
                return;
            hdr = unit_idx - 1;
            if (!unit_marks[hdr])
                return;
            pg = PAGE_W'(hdr / PAGE_UNITS);
            unit_marks[hdr] = 1'b0;
            if (page_refs[pg] > 0)
                page_refs[pg] = page_refs[pg] - 1'b1;
            frees_done = frees_done + 1'b1;
            // an empty page rewinds if current, otherwise goes back on the stack
            if (page_refs[pg] == 0) begin
                if (cur_valid && pg == cur_page) begin
                    page_fill[pg] = '0;
                end else if (stack_depth < NUM_PAGES) begin
                    page_fill[pg] = '0;
                    free_stack[stack_depth] = pg;
                    stack_depth = stack_depth + 1'b1;
                    released = 1'b1;
                end
            end
            st = STAT_OK;
            for (int i = 0; i < live_addrs.size(); i++) begin
                if (live_addrs[i] == addr) begin
                    live_addrs.delete(i);
                    break;
                end
            end
            freed_addrs.push_back(addr);
            if (freed_addrs.size() > 16)
                void'(freed_addrs.pop_front());
        endfunction

        function void note_item(input logic cmd, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] faddr);
            t_alloc_reply      r;
            logic [STAT_W-1:0] st;
            logic [ADDR_W-1:0] addr;
            logic              released;
            r = '0;
            if (cmd == CMD_ALLOC) begin
                predict_alloc(size, st, addr);
                r.address = addr;
            end else begin
                predict_free(faddr, st, released);
                r.page_released = released;
            end
            r.status      = st;
            r.alloc_count = allocs_done;
            r.free_count  = frees_done;
            r.alloc_bytes = bytes_done;
            predicted_replies.push_back(r);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(input logic [STAT_W-1:0] st, input logic [ADDR_W-1:0] addr,
                          input logic released, input logic [CNT_W-1:0] n_alloc,
                          input logic [CNT_W-1:0] n_free, input logic [CNT_W-1:0] n_bytes);
            t_alloc_reply want;
            if (predicted_replies.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            want = predicted_replies.pop_front();
            if (st !== want.status)
                report($sformatf("status got %0d want %0d", st, want.status));
            if (addr !== want.address)
                report($sformatf("address got %0h want %0h", addr, want.address));
            if (released !== want.page_released)
                report($sformatf("page_released got %0b want %0b",
                                 released, want.page_released));
            if (n_alloc !== want.alloc_count)
                report($sformatf("alloc_count got %0d want %0d", n_alloc, want.alloc_count));
            if (n_free !== want.free_count)
                report($sformatf("free_count got %0d want %0d", n_free, want.free_count));
            if (n_bytes !== want.alloc_bytes)
                report($sformatf("alloc_bytes got %0d want %0d", n_bytes, want.alloc_bytes));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cfg_we;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              i_cmd;
    logic [SIZE_W-1:0] i_alloc_size;
    logic [ADDR_W-1:0] i_free_address;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_address;
    logic              o_page_released;
    logic [CNT_W-1:0]  o_alloc_count;
    logic [CNT_W-1:0]  o_free_count;
    logic [CNT_W-1:0]  o_alloc_bytes;

    t_alloc_scoreboard sb;
    int                sent;

    refcounted_bump_page_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (i_cmd),
        .i_alloc_size    (i_alloc_size),
        .i_free_address  (i_free_address),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_address       (o_address),
        .o_page_released (o_page_released),
        .o_alloc_count   (o_alloc_count),
        .o_free_count    (o_free_count),
        .o_alloc_bytes   (o_alloc_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_status, o_address, o_page_released,
                            o_alloc_count, o_free_count, o_alloc_bytes);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_item(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] faddr);
        if (!(sent >= 700 && sent < 1000) && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_alloc_size   <= size;
        i_free_address <= faddr;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(cmd, size, faddr);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_alloc(input int size);
        drive_item(CMD_ALLOC, SIZE_W'(size), ADDR_W'($urandom_range(0, 262143)));
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        drive_item(CMD_FREE, SIZE_W'($urandom_range(0, 65535)), addr);
    endtask

    task automatic send_random(input int alloc_pct);
        int                r;
        int                cap;
        int                lo;
        int                n_live;
        logic [ADDR_W-1:0] addr;
        cap    = sb.usable_units();
        n_live = sb.live_addrs.size();
        r      = $urandom_range(0, 99);
        if (n_live == 0 || $urandom_range(0, 99) < alloc_pct) begin
            if (r < 50) begin
                send_alloc($urandom_range(0, 64));
            end else if (r < 75) begin
                send_alloc($urandom_range(0, cap * 8 + 8));
            end else if (r < 88) begin
                // straddle the exact-fit boundary
                lo = cap * 8 - 15;
                if (lo < 0)
                    lo = 0;
                send_alloc(lo + $urandom_range(0, 15));
            end else begin
                send_alloc($urandom_range(0, 65535));
            end
        end else begin
            if (r < 70)
                addr = sb.live_addrs[$urandom_range(0, n_live - 1)];
            else if (r < 80 && sb.freed_addrs.size() > 0)
                addr = sb.freed_addrs[$urandom_range(0, sb.freed_addrs.size() - 1)];
            else if (r < 90)
                addr = ADDR_W'($urandom_range(0, 262143));
            else if (r < 95)
                addr = ADDR_W'($urandom_range(0, NUM_PAGES - 1) * PAGE_UNITS * 8);
            else
                addr = sb.live_addrs[$urandom_range(0, n_live - 1)] +
                       ADDR_W'($urandom_range(1, 7));
            send_free(addr);
        end
    endtask

    // Drop start and hold until every outstanding item has reported.
    task automatic settle();
        start <= 1'b0;
        while (sb.predicted_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CAP_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.cap_reg = CAP_W'(value);
    endtask

    initial begin
        int phase_cap   [8] = '{508, 2, 0, 1023, 40, 512, 300, 508};
        int phase_items [8] = '{230, 120, 12, 300, 250, 250, 230, 230};
        int phase_alloc [8] = '{55, 50, 60, 60, 65, 25, 50, 55};

        sb             = new();
        sent           = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_cmd          = CMD_ALLOC;
        i_alloc_size   = '0;
        i_free_address = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing pass
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);

        send_alloc(0);
        send_alloc(1);
        send_alloc(65535);
        send_alloc(4057);
        send_alloc(4056);
        send_free(18'd8);
        send_free(18'd8);
        send_free(18'd9);
        send_free(18'd0);
        send_free(18'd4096);
        send_free(18'h3FFFF);
        send_free(18'h3FFF8);
        send_free(18'd16);
        send_free(18'd4104);
        send_alloc(100);
        send_free(18'd4104);
        send_alloc(4056);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_capacity(phase_cap[p]);
            // burst of small items, most taking a page each, runs the pool dry
            if (phase_cap[p] == 2) begin
                repeat (70) send_alloc($urandom_range(0, 8));
            end
            repeat (phase_items[p]) send_random(phase_alloc[p]);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
